// ----- rtl/pctd_pkg.sv -----
// Shared types and constants for the prefix-code table decoder.
// No dependencies; imported by pctd_cam and prefix_code_table_decoder.

package pctd_pkg;

	// Field widths of the input and result words
	localparam int OP_W        = 2;
	localparam int SYM_W       = 8;
	localparam int CODE_W      = 16;
	localparam int LEN_FIELD_W = 5;
	localparam int ST_W        = 2;

	// Parameter defaults
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_CODE_LEN_DEF  = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
	localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_SYMBOL   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	// Search key presented to the code table
	typedef struct packed {
		logic                   en;
		logic [CODE_W-1:0]      code;
		logic [LEN_FIELD_W-1:0] len;
	} pctd_key_t;

	// Table write request; a new entry takes its code and length from the key
	typedef struct packed {
		logic             add;
		logic             replace;
		logic [SYM_W-1:0] symbol;
	} pctd_wr_t;

endpackage

// ----- rtl/pctd_cam.sv -----
// Code table of the prefix-code decoder: entry storage with a parallel
// compare of one key against every filled entry. Depends on pctd_pkg.

module pctd_cam #(
	parameter int TABLE_ENTRIES = pctd_pkg::TABLE_ENTRIES_DEF,
	parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                          clk,
	input  logic [CNT_W-1:0]              entry_count,
	input  pctd_pkg::pctd_key_t           key,
	input  pctd_pkg::pctd_wr_t            wr,
	output logic                          hit,
	output logic [pctd_pkg::SYM_W-1:0]    hit_symbol
);
	import pctd_pkg::*;

	logic [CODE_W-1:0]      code_q [TABLE_ENTRIES];
	logic [LEN_FIELD_W-1:0] len_q  [TABLE_ENTRIES];
	logic [SYM_W-1:0]       sym_q  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] match;

	// Compare key with every filled entry; only the first entry_count are live
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = key.en && (CNT_W'(i) < entry_count)
				&& (len_q[i] == key.len) && (code_q[i] == key.code);
		end
	end

	// Codes are unique, so at most one match: OR the selected symbols
	always_comb begin
		hit_symbol = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_symbol = hit_symbol | (match[i] ? sym_q[i] : '0);
		end
	end

	assign hit = |match;

	// Append at entry_count, or replace the symbol of the matching entry
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (wr.add && (CNT_W'(i) == entry_count)) begin
				code_q[i] <= key.code;
				len_q[i]  <= key.len;
				sym_q[i]  <= wr.symbol;
			end else if (wr.replace && match[i]) begin
				sym_q[i] <= wr.symbol;
			end
		end
	end

endmodule

// ----- rtl/prefix_code_table_decoder.sv -----
// Top level of the prefix-code table decoder: input register, bit
// accumulator, entry count and result register. Depends on pctd_pkg, pctd_cam.

// Takes one word per clock while in_stall is low: a table clear, a table
// load or one code bit. Each word is registered in the input register,
// then compared against all stored codes at once; the table and
// accumulator are updated and any result is written to the output
// register when the result slot is free. Words follow back to back; while
// a result waits under out_stall, one more word is held in the input
// register before in_stall rises. The table needs no clearing pass after
// reset: only the first entry_count entries are ever compared. A load
// returns table full (status 1) when its code is new and all TABLE_ENTRIES
// are used; a decode returns a symbol (status 0) on a match, or overflow
// (status 2) once MAX_CODE_LEN bits gather without one.

module prefix_code_table_decoder #(
	parameter int TABLE_ENTRIES = pctd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_LEN  = pctd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pctd_pkg::OP_W-1:0]        operation,
	input  logic [pctd_pkg::SYM_W-1:0]       entry_symbol,
	input  logic [pctd_pkg::CODE_W-1:0]      entry_bits,
	input  logic [pctd_pkg::LEN_FIELD_W-1:0] entry_length,
	input  logic                             code_bit,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pctd_pkg::ST_W-1:0]        status,
	output logic [pctd_pkg::SYM_W-1:0]       symbol
);
	import pctd_pkg::*;

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	// wide enough for both MAX_CODE_LEN and CODE_W
	localparam int LEN_W = $clog2(((MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W) + 1);
	localparam logic [LEN_FIELD_W-1:0] LOAD_LEN_MAX =
		LEN_FIELD_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

	// Input register
	logic                   valid_s1;
	logic [OP_W-1:0]        op_s1;
	logic [SYM_W-1:0]       sym_s1;
	logic [CODE_W-1:0]      bits_s1;
	logic [LEN_FIELD_W-1:0] len_s1;
	logic                   bit_s1;

	// Decoder state
	logic [CNT_W-1:0]  entry_count_q;
	logic [CODE_W-1:0] accum_code_q;
	logic [LEN_W-1:0]  accum_len_q;

	// Result register
	logic              out_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [SYM_W-1:0]  symbol_q;

	logic              out_free;
	logic              fire;
	logic              is_clear;
	logic              is_load;
	logic              is_decode;
	logic              load_ok;
	logic [CODE_W-1:0] load_code;
	logic [CODE_W-1:0] dec_code;
	logic [LEN_W-1:0]  dec_len;
	logic              dec_key_ok;
	logic              dec_over;
	logic              table_full;
	pctd_key_t         key;
	pctd_wr_t          wr;
	logic              hit;
	logic [SYM_W-1:0]  hit_symbol;
	logic              res_valid;
	logic [ST_W-1:0]   res_status;
	logic [SYM_W-1:0]  res_symbol;

	// Handshake: the held word moves on whenever the result slot frees
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1   <= operation;
			sym_s1  <= entry_symbol;
			bits_s1 <= entry_bits;
			len_s1  <= entry_length;
			bit_s1  <= code_bit;
		end
	end

	// Decode the word
	assign is_clear  = op_s1 == OP_CLEAR;
	assign is_load   = op_s1 == OP_LOAD;
	assign is_decode = op_s1 == OP_DECODE;

	// Load: legal length, code masked to its low len bits
	assign load_ok   = (len_s1 != '0) && (len_s1 <= LOAD_LEN_MAX);
	assign load_code = bits_s1 & ~({CODE_W{1'b1}} << len_s1);

	// Decode: shift in one bit; codes longer than CODE_W never match
	assign dec_code   = {accum_code_q[CODE_W-2:0], bit_s1};
	assign dec_len    = accum_len_q + LEN_W'(1);
	assign dec_key_ok = dec_len <= LEN_W'(CODE_W);
	assign dec_over   = dec_len >= LEN_W'(MAX_CODE_LEN);

	assign table_full = entry_count_q >= CNT_W'(TABLE_ENTRIES);

	// Table search key
	always_comb begin
		key.en   = 1'b0;
		key.code = load_code;
		key.len  = len_s1;
		if (is_load) begin
			key.en = load_ok;
		end else if (is_decode) begin
			key.en   = dec_key_ok;
			key.code = dec_code;
			key.len  = LEN_FIELD_W'(dec_len);
		end
	end

	// Table writes
	assign wr.add     = fire && is_load && load_ok && !hit && !table_full;
	assign wr.replace = fire && is_load && load_ok && hit;
	assign wr.symbol  = sym_s1;

	pctd_cam #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.CNT_W        (CNT_W)
	) u_cam (
		.clk        (clk),
		.entry_count(entry_count_q),
		.key        (key),
		.wr         (wr),
		.hit        (hit),
		.hit_symbol (hit_symbol)
	);

	// Result of this word, if any
	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_SYMBOL;
		res_symbol = '0;
		if (is_load && load_ok && !hit && table_full) begin
			res_valid  = 1'b1;
			res_status = ST_FULL;
		end else if (is_decode && hit) begin
			res_valid  = 1'b1;
			res_symbol = hit_symbol;
		end else if (is_decode && dec_over) begin
			res_valid  = 1'b1;
			res_status = ST_OVERFLOW;
		end
	end

	// Entry count and bit accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			accum_code_q  <= '0;
			accum_len_q   <= '0;
		end else if (fire) begin
			if (is_clear) begin
				entry_count_q <= '0;
				accum_code_q  <= '0;
				accum_len_q   <= '0;
			end else if (is_decode) begin
				if (hit || dec_over) begin
					accum_code_q <= '0;
					accum_len_q  <= '0;
				end else begin
					accum_code_q <= dec_code;
					accum_len_q  <= dec_len;
				end
			end else if (wr.add) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			status_q <= res_status;
			symbol_q <= res_symbol;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign symbol    = symbol_q;

	// Checks
	a_accum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accum_len_q < LEN_W'(MAX_CODE_LEN))
		else $error("accumulator length reached MAX_CODE_LEN");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_clear |=> entry_count_q == '0 && accum_len_q == '0)
		else $error("clear did not empty table and accumulator");

	a_decode_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_decode && res_valid |=> accum_len_q == '0 && out_valid_q)
		else $error("decode result did not reset accumulator");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held result");

endmodule
